FILE: rtl/ihexw_pkg.sv
// Shared types, constants and helpers of the HEX record writer.
// No dependencies; every other file of the block but ihexw_ram imports this package.
`default_nettype none

package ihexw_pkg;

   localparam int LINE_BYTES_DEF = 16;   // bytes per data record
   localparam int CNT_W          = 5;    // pending byte count
   localparam int ADDR_W         = 16;
   localparam int BYTE_W         = 8;
   localparam int QUEUE_DEPTH    = 2;    // commands between front and back
   localparam int HEX_W          = 72;   // longest nibble run of one record
   localparam int NIB_W          = 5;    // counts up to 18 nibbles

   localparam logic [ADDR_W-1:0] NO_START       = 16'hFFFF;
   localparam logic [7:0]        START_SUM_BASE = 8'h09;
   // count 04, address 0000, type 05, upper start word 0000
   localparam logic [47:0]       START_HEAD     = 48'h04_0000_05_0000;
   // count 00, address 0000, type 01, checksum FF
   localparam logic [39:0]       EOF_NIBS       = 40'h00_0000_01_FF;
   localparam logic [7:0]        CH_COLON       = 8'h3A;
   localparam logic [7:0]        CH_NL          = 8'h0A;

   typedef enum logic [1:0] {
      ACT_DATA  = 2'd0,
      ACT_FLUSH = 2'd1,
      ACT_END   = 2'd2
   } act_type;

   typedef enum logic {
      CMD_DATA,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                bank;
      logic [CNT_W-1:0]    count;
      logic [ADDR_W-1:0]   address;
      logic                has_start;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } free_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_COLON,
      BE_HEAD,
      BE_DATA,
      BE_NL
   } be_state_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/intel_hex_record_writer.sv
// Top level of the Intel HEX record writer: start address register,
// front end, command queue, line bank RAM and record sequencer.
// Depends on ihexw_pkg, ihexw_front, ihexw_cmd_fifo, ihexw_ram, ihexw_back.
//
//   channel  direction  beat carries
//   -------  ---------  -------------------------------------------
//   csr      in         start_address (16 bits)
//   req      in         action, address, data_byte
//   rsp      out        out_char (ASCII), last_char
//
// The front end takes one req beat per cycle while a bank and a queue slot
// are free; two 16-byte line banks in one RAM let it fill a new line while
// the sequencer writes out the previous one.
// The sequencer sends one character per cycle while rsp is ready: a data
// record of n bytes is 12 + 2n beats, the end records 12 or 32 beats, and
// the sequencer passes its idle state once per command to pop the queue.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled rsp holds the character register; req stalls once both banks
// or both queue slots are taken.
`default_nettype none

module intel_hex_record_writer #(
   parameter int LINE_BYTES = ihexw_pkg::LINE_BYTES_DEF,
   localparam int IDX_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ihexw_pkg::ADDR_W-1:0]  csr_start_address,
   // requests
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [ihexw_pkg::ADDR_W-1:0]  req_address,
   input  wire logic [ihexw_pkg::BYTE_W-1:0]  req_data_byte,
   // characters
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_char,
   output logic                               rsp_last_char
);
   import ihexw_pkg::*;

   localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

   logic [ADDR_W-1:0] start_ff, start_in;

   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   cmd_type           q_push_cmd;
   cmd_type           q_pop_cmd;
   free_type          bank_free;

   logic              ram_we;
   logic [IDX_W:0]    ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [IDX_W:0]    ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   // Start address register: always ready; user must write only while idle, unchecked.
   assign csr_ready = 1'b1;

   always_comb begin
      start_in = start_ff;
      if (csr_valid && csr_ready) begin
         start_in = csr_start_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= NO_START;
      end else begin
         start_ff <= start_in;
      end
   end

   // Front end: classify the beat, gather bytes, queue record commands.
   ihexw_front #(
      .LINE_BYTES (LINE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_address   (req_address),
      .req_data_byte (req_data_byte),
      .start_address (start_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_push_cmd),
      .bank_free     (bank_free),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata)
   );

   // Decouple the two sides so each can stall on its own.
   ihexw_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   // Two line banks: bank bit on top, byte index below.
   ihexw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Record sequencer: one character per beat, a data bank freed as its newline goes out.
   ihexw_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_cmd         (q_pop_cmd),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .bank_free     (bank_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

FILE: rtl/ihexw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ihexw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ihexw_cmd_fifo.sv
// Short command queue between the front end and the record sequencer.
// Depends on ihexw_pkg.
`default_nettype none

module ihexw_cmd_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ihexw_pkg::cmd_type  push_cmd,
   output logic                     full,
   input  wire logic                pop,
   output ihexw_pkg::cmd_type       pop_cmd,
   output logic                     empty
);
   import ihexw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff,  count_in;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ihexw_front.sv
// Front end: accepts request beats, gathers bytes into two line banks
// and queues record commands. Depends on ihexw_pkg.
`default_nettype none

module ihexw_front #(
   parameter int LINE_BYTES = ihexw_pkg::LINE_BYTES_DEF,
   localparam int IDX_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_action,
   input  wire logic [ihexw_pkg::ADDR_W-1:0]    req_address,
   input  wire logic [ihexw_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic [ihexw_pkg::ADDR_W-1:0]    start_address,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output ihexw_pkg::cmd_type                   q_cmd,
   input  wire ihexw_pkg::free_type             bank_free,
   output logic                                 ram_we,
   output logic [IDX_W:0]                       ram_waddr,
   output logic [ihexw_pkg::BYTE_W-1:0]         ram_wdata
);
   import ihexw_pkg::*;

   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic [ADDR_W-1:0] line_addr_ff, line_addr_in;
   logic              cur_bank_ff,  cur_bank_in;
   logic [1:0]        busy_ff,      busy_in;

   logic [ADDR_W:0]   follow_addr;
   logic              brk;
   logic              flush_old;
   logic              tgt_bank;
   logic [CNT_W-1:0]  idx_base;
   logic [CNT_W-1:0]  new_cnt;
   logic              fill;
   logic [ADDR_W-1:0] line_start;
   logic              need_push;
   logic              accept;

   // contiguity check runs without 16-bit wrap
   assign follow_addr = {1'b0, line_addr_ff} + (ADDR_W+1)'(cnt_ff);
   assign brk         = ({1'b0, req_address} != follow_addr);
   assign flush_old   = brk && (cnt_ff != '0);
   assign tgt_bank    = flush_old ? ~cur_bank_ff : cur_bank_ff;
   assign idx_base    = brk ? '0 : cnt_ff;
   assign new_cnt     = idx_base + 1'b1;
   assign fill        = (new_cnt == CNT_W'(LINE_BYTES));
   assign line_start  = brk ? req_address : line_addr_ff;

   always_comb begin
      need_push       = 1'b0;
      req_ready       = 1'b1;
      q_cmd.kind      = CMD_DATA;
      q_cmd.bank      = cur_bank_ff;
      q_cmd.count     = cnt_ff;
      q_cmd.address   = line_addr_ff;
      q_cmd.has_start = 1'b0;
      case (req_action)
         ACT_DATA: begin
            need_push = flush_old || fill;
            if (!flush_old) begin
               q_cmd.bank    = tgt_bank;
               q_cmd.count   = CNT_W'(LINE_BYTES);
               q_cmd.address = line_start;
            end
            req_ready = !busy_ff[tgt_bank] && (!need_push || !q_full);
         end
         ACT_FLUSH: begin
            need_push = (cnt_ff != '0);
            req_ready = !need_push || !q_full;
         end
         ACT_END: begin
            need_push       = 1'b1;
            q_cmd.kind      = CMD_END;
            q_cmd.address   = start_address;
            q_cmd.has_start = (start_address != NO_START);
            req_ready       = !q_full;
         end
         default: begin
            need_push = 1'b0;
            req_ready = 1'b1;
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign q_push    = accept && need_push;
   assign ram_we    = accept && (req_action == ACT_DATA);
   assign ram_waddr = {tgt_bank, idx_base[IDX_W-1:0]};
   assign ram_wdata = req_data_byte;

   always_comb begin
      cnt_in       = cnt_ff;
      line_addr_in = line_addr_ff;
      cur_bank_in  = cur_bank_ff;
      busy_in      = busy_ff;
      if (accept) begin
         case (req_action)
            ACT_DATA: begin
               if (fill) begin
                  cnt_in       = '0;
                  line_addr_in = line_start + ADDR_W'(LINE_BYTES);
                  cur_bank_in  = ~tgt_bank;
               end else begin
                  cnt_in       = new_cnt;
                  line_addr_in = line_start;
                  cur_bank_in  = tgt_bank;
               end
            end
            ACT_FLUSH: begin
               if (cnt_ff != '0) begin
                  cnt_in      = '0;
                  cur_bank_in = ~cur_bank_ff;
               end
            end
            ACT_END: begin
               // drop whatever is pending
               cnt_in = '0;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end
      if (q_push && (q_cmd.kind == CMD_DATA)) begin
         busy_in[q_cmd.bank] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         line_addr_ff <= '0;
         cur_bank_ff  <= 1'b0;
         busy_ff      <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         line_addr_ff <= line_addr_in;
         cur_bank_ff  <= cur_bank_in;
         busy_ff      <= busy_in;
      end
   end

   a_cnt_below_line: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(LINE_BYTES))
      else $error("pending count reached a full line");

   a_no_busy_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !busy_ff[ram_waddr[IDX_W]])
      else $error("byte written into a bank the sequencer still owns");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_free_owned: assert property (@(posedge clock) disable iff (reset)
      bank_free.valid |-> busy_ff[bank_free.bank])
      else $error("bank freed that was not owned");

endmodule

`default_nettype wire

FILE: rtl/ihexw_back.sv
// Back end: record sequencer that turns queued commands into HEX text,
// one character per beat. Depends on ihexw_pkg.
`default_nettype none

module ihexw_back #(
   parameter int LINE_BYTES = ihexw_pkg::LINE_BYTES_DEF,
   localparam int IDX_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   output logic                            q_pop,
   input  wire ihexw_pkg::cmd_type         q_cmd,
   output logic                            ram_re,
   output logic [IDX_W:0]                  ram_raddr,
   input  wire logic [ihexw_pkg::BYTE_W-1:0] ram_rdata,
   output ihexw_pkg::free_type             bank_free,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_char,
   output logic                            rsp_last_char
);
   import ihexw_pkg::*;

   be_state_type      state_ff, state_in;
   logic [HEX_W-1:0]  hex_ff,      hex_in;
   logic [NIB_W-1:0]  nib_ff,      nib_in;
   logic              upper_ff,    upper_in;
   logic              to_data_ff,  to_data_in;
   logic              rec_data_ff, rec_data_in;
   logic              eof_pend_ff, eof_pend_in;
   logic              bank_ff,     bank_in;
   logic [CNT_W-1:0]  left_ff,     left_in;
   logic [IDX_W-1:0]  idx_ff,      idx_in;
   logic              lo_ff,       lo_in;
   logic [7:0]        sum_ff,      sum_in;
   logic              valid_ff,    valid_in;
   logic [7:0]        char_ff,     char_in;
   logic              last_ff,     last_in;

   logic              step;
   logic [7:0]        sum_next;
   logic [7:0]        start_sum;

   assign step      = (state_ff != BE_IDLE) && (!valid_ff || rsp_ready);
   assign q_pop     = (state_ff == BE_IDLE) && !q_empty;
   assign sum_next  = sum_ff + ram_rdata;
   assign start_sum = START_SUM_BASE + q_cmd.address[15:8] + q_cmd.address[7:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: begin
            if (!q_empty) begin
               state_in = BE_COLON;
            end
         end
         BE_COLON: begin
            if (step) begin
               state_in = BE_HEAD;
            end
         end
         BE_HEAD: begin
            if (step && (nib_ff == NIB_W'(1))) begin
               state_in = to_data_ff ? BE_DATA : BE_NL;
            end
         end
         BE_DATA: begin
            if (step && lo_ff && (left_ff == CNT_W'(1))) begin
               state_in = BE_HEAD;
            end
         end
         BE_NL: begin
            if (step) begin
               state_in = eof_pend_ff ? BE_COLON : BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_comb begin
      hex_in      = hex_ff;
      nib_in      = nib_ff;
      upper_in    = upper_ff;
      to_data_in  = to_data_ff;
      rec_data_in = rec_data_ff;
      eof_pend_in = eof_pend_ff;
      bank_in     = bank_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      sum_in      = sum_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      ram_re      = 1'b0;
      ram_raddr   = {bank_ff, IDX_W'(idx_ff + 1'b1)};
      bank_free   = '{valid: 1'b0, bank: bank_ff};

      // hold the beat until taken, drop it when taken with nothing new
      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      if (q_pop) begin
         lo_in    = 1'b0;
         idx_in   = '0;
         bank_in  = q_cmd.bank;
         left_in  = q_cmd.count;
         if (q_cmd.kind == CMD_DATA) begin
            hex_in      = {3'b000, q_cmd.count, q_cmd.address, 8'h00, 40'h0};
            nib_in      = NIB_W'(8);
            upper_in    = 1'b1;
            to_data_in  = 1'b1;
            rec_data_in = 1'b1;
            eof_pend_in = 1'b0;
            sum_in      = {3'b000, q_cmd.count} + q_cmd.address[15:8]
                          + q_cmd.address[7:0];
            // prefetch the first byte of the line
            ram_re      = 1'b1;
            ram_raddr   = {q_cmd.bank, {IDX_W{1'b0}}};
         end else if (q_cmd.has_start) begin
            hex_in      = {START_HEAD, q_cmd.address, 8'h00 - start_sum};
            nib_in      = NIB_W'(18);
            upper_in    = 1'b0;
            to_data_in  = 1'b0;
            rec_data_in = 1'b0;
            eof_pend_in = 1'b1;
         end else begin
            hex_in      = {EOF_NIBS, 32'h0};
            nib_in      = NIB_W'(10);
            upper_in    = 1'b1;
            to_data_in  = 1'b0;
            rec_data_in = 1'b0;
            eof_pend_in = 1'b0;
         end
      end

      if (step) begin
         case (state_ff)
            BE_COLON: begin
               char_in = CH_COLON;
               last_in = 1'b0;
            end
            BE_HEAD: begin
               char_in = hex_char(hex_ff[HEX_W-1 -: 4], upper_ff);
               last_in = 1'b0;
               hex_in  = {hex_ff[HEX_W-5:0], 4'h0};
               nib_in  = nib_ff - 1'b1;
            end
            BE_DATA: begin
               last_in = 1'b0;
               if (!lo_ff) begin
                  char_in = hex_char(ram_rdata[7:4], upper_ff);
                  lo_in   = 1'b1;
               end else begin
                  char_in = hex_char(ram_rdata[3:0], upper_ff);
                  lo_in   = 1'b0;
                  sum_in  = sum_next;
                  left_in = left_ff - 1'b1;
                  idx_in  = IDX_W'(idx_ff + 1'b1);
                  ram_re  = 1'b1;
                  if (left_ff == CNT_W'(1)) begin
                     // line done: checksum goes out through the nibble shifter
                     hex_in     = {8'h00 - sum_next, 64'h0};
                     nib_in     = NIB_W'(2);
                     to_data_in = 1'b0;
                  end
               end
            end
            BE_NL: begin
               char_in = CH_NL;
               last_in = !eof_pend_ff;
               if (rec_data_ff) begin
                  bank_free = '{valid: 1'b1, bank: bank_ff};
               end
               if (eof_pend_ff) begin
                  hex_in      = {EOF_NIBS, 32'h0};
                  nib_in      = NIB_W'(10);
                  upper_in    = 1'b1;
                  eof_pend_in = 1'b0;
               end
            end
            default: begin
               char_in = char_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BE_IDLE;
         valid_ff    <= 1'b0;
         rec_data_ff <= 1'b0;
         eof_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         rec_data_ff <= rec_data_in;
         eof_pend_ff <= eof_pend_in;
      end
      hex_ff     <= hex_in;
      nib_ff     <= nib_in;
      upper_ff   <= upper_in;
      to_data_ff <= to_data_in;
      bank_ff    <= bank_in;
      left_ff    <= left_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      sum_ff     <= sum_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

`default_nettype wire
